FILE: rtl/iws_pkg.sv
// Shared types, constants and helpers for the image wrap-shift engine.
// No dependencies; every other file in rtl except iws_ram imports this package.
package iws_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int PIXEL_W     = 32;
  localparam int DIM_W       = 9;
  localparam int COORD_W     = 8;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int FRAC_W      = 18;
  localparam int PROD_W      = DIM_W + 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 18;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_XSHIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YSHIFT = 3'd3;

  typedef struct packed {
    logic load;
    logic fetch_init;
    logic red_step;
    logic red_commit;
    logic prod;
    logic ofs;
    logic src;
    logic rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic loaded;
    logic need_reduce;
    logic out_free;
  } status_t;

  function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/iws_if.sv
// Channel interfaces: pixel item stream, result stream, register write port.
// Depends on iws_pkg for widths.
interface iws_item_if;
  import iws_pkg::*;
  logic               valid;
  logic               ready;
  logic               command;
  logic [PIXEL_W-1:0] pixel_in;
  modport source (output valid, output command, output pixel_in, input ready);
  modport sink   (input valid, input command, input pixel_in, output ready);
endinterface

interface iws_result_if;
  import iws_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_out;
  logic               ready_res;
  logic               last_pixel;
  modport source (output valid, output pixel_out, output ready_res, output last_pixel,
                  input ready);
  modport sink   (input valid, input pixel_out, input ready_res, input last_pixel,
                  output ready);
endinterface

interface iws_cfg_if;
  import iws_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/iws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/iws_ctrl.sv
// Sequencer for load and fetch transactions of the wrap-shift engine.
// Depends on iws_pkg; drives the datapath through cmd_t, watches status_t.
module iws_ctrl
  import iws_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_command_i,
  output logic    in_ready_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  localparam int STEP_W = $clog2(COORD_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COORD_W - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_PROD = 3'd2;
  localparam logic [2:0] ST_OFS  = 3'd3;
  localparam logic [2:0] ST_SRC  = 3'd4;
  localparam logic [2:0] ST_ADDR = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_command_i == CMD_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.fetch_init = 1'b1;
            step_d           = '0;
            if (!sts_i.loaded) begin
              state_d = ST_OUT;
            end else if (sts_i.need_reduce) begin
              state_d = ST_RED;
            end else begin
              state_d = ST_PROD;
            end
          end
        end
      end
      ST_RED: begin
        cmd_o.red_step = 1'b1;
        if (step_q == STEP_LAST) begin
          cmd_o.red_commit = 1'b1;
          state_d          = ST_PROD;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_OFS;
      end
      ST_OFS: begin
        cmd_o.ofs = 1'b1;
        state_d   = ST_SRC;
      end
      ST_SRC: begin
        cmd_o.src = 1'b1;
        state_d   = ST_ADDR;
      end
      ST_ADDR: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

FILE: rtl/iws_dp.sv
// Datapath: config registers, load/output positions, shift offset math,
// source address, frame store and result register. Depends on iws_pkg, iws_ram.
module iws_dp
  import iws_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               sts_o,
  input  logic [PIXEL_W-1:0]    pixel_in_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_W-1:0]    pixel_out_o,
  output logic                  ready_res_o,
  output logic                  last_pixel_o
);

  localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_HEIGHT);
  localparam logic [PROD_W-1:0] HALF = PROD_W'(32768);

  // config
  logic [DIM_W-1:0]  width_q, height_q;
  logic [FRAC_W-1:0] xfrac_q, yfrac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= MAX_W;
      height_q <= MAX_H;
      xfrac_q  <= '0;
      yfrac_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        REG_XSHIFT: xfrac_q  <= cfg_data_i[FRAC_W-1:0];
        REG_YSHIFT: yfrac_q  <= cfg_data_i[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0]  w, h;
  logic [ADDR_W:0]   total;

  assign w     = clamp_size(width_q, MAX_W);
  assign h     = clamp_size(height_q, MAX_H);
  assign total = (ADDR_W + 1)'(w) * (ADDR_W + 1)'(h);

  // load side
  logic               loaded_q;
  logic [ADDR_W-1:0]  pos_q;
  logic [ADDR_W-1:0]  pos_cur;
  logic [ADDR_W:0]    pos_inc;

  assign pos_cur = loaded_q ? '0 : pos_q;
  assign pos_inc = {1'b0, pos_cur} + (ADDR_W + 1)'(1);

  // output position and reduction
  logic [COORD_W-1:0] row_q, col_q;
  logic [COORD_W-1:0] div_r_q, div_c_q, rem_r_q, rem_c_q;
  logic [COORD_W:0]   tmp_r, tmp_c;
  logic [COORD_W-1:0] red_r, red_c;

  assign tmp_r = {rem_r_q, div_r_q[COORD_W-1]};
  assign tmp_c = {rem_c_q, div_c_q[COORD_W-1]};
  assign red_r = (tmp_r >= h) ? COORD_W'(tmp_r - h) : tmp_r[COORD_W-1:0];
  assign red_c = (tmp_c >= w) ? COORD_W'(tmp_c - w) : tmp_c[COORD_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_init) begin
      div_r_q <= row_q;
      div_c_q <= col_q;
      rem_r_q <= '0;
      rem_c_q <= '0;
    end else if (cmd_i.red_step) begin
      div_r_q <= {div_r_q[COORD_W-2:0], 1'b0};
      div_c_q <= {div_c_q[COORD_W-2:0], 1'b0};
      rem_r_q <= red_r;
      rem_c_q <= red_c;
    end
  end

  // shift offsets
  logic [FRAC_W-1:0] xneg, yneg;
  logic [15:0]       xf, yf;
  logic [PROD_W-1:0] prod_x_q, prod_y_q, sum_x, sum_y;
  logic [DIM_W-1:0]  off_x, off_y, offz_x, offz_y, dx, dy;
  logic [COORD_W-1:0] dx_q, dy_q;

  assign xneg = ~xfrac_q + FRAC_W'(1);
  assign yneg = ~yfrac_q + FRAC_W'(1);
  assign xf   = xfrac_q[FRAC_W-1] ? xneg[15:0] : xfrac_q[15:0];
  assign yf   = yfrac_q[FRAC_W-1] ? yneg[15:0] : yfrac_q[15:0];

  assign sum_x  = prod_x_q + HALF;
  assign sum_y  = prod_y_q + HALF;
  assign off_x  = sum_x[PROD_W-1:16];
  assign off_y  = sum_y[PROD_W-1:16];
  assign offz_x = (off_x >= w) ? '0 : off_x;
  assign offz_y = (off_y >= h) ? '0 : off_y;
  assign dx     = (xfrac_q[FRAC_W-1] && offz_x != '0) ? w - offz_x : offz_x;
  assign dy     = (yfrac_q[FRAC_W-1] && offz_y != '0) ? h - offz_y : offz_y;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      prod_x_q <= PROD_W'(w) * PROD_W'(xf);
      prod_y_q <= PROD_W'(h) * PROD_W'(yf);
    end
    if (cmd_i.ofs) begin
      dx_q <= dx[COORD_W-1:0];
      dy_q <= dy[COORD_W-1:0];
    end
  end

  // source coordinates
  logic [DIM_W:0]     sum_c, sum_r;
  logic [COORD_W-1:0] sc, sr, sc_q, sr_q;
  logic               last_q;
  logic [DIM_W-1:0]   col_inc, row_inc;

  assign sum_c = (DIM_W + 1)'(col_q) + (DIM_W + 1)'(w) - (DIM_W + 1)'(dx_q);
  assign sum_r = (DIM_W + 1)'(row_q) + (DIM_W + 1)'(h) - (DIM_W + 1)'(dy_q);
  assign sc    = (sum_c >= (DIM_W + 1)'(w)) ? COORD_W'(sum_c - (DIM_W + 1)'(w))
                                            : sum_c[COORD_W-1:0];
  assign sr    = (sum_r >= (DIM_W + 1)'(h)) ? COORD_W'(sum_r - (DIM_W + 1)'(h))
                                            : sum_r[COORD_W-1:0];
  assign col_inc = DIM_W'(col_q) + DIM_W'(1);
  assign row_inc = DIM_W'(row_q) + DIM_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.src) begin
      sc_q   <= sc;
      sr_q   <= sr;
      last_q <= (DIM_W'(row_q) == h - DIM_W'(1)) && (DIM_W'(col_q) == w - DIM_W'(1));
    end
  end

  // position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      pos_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
    end else if (cmd_i.load) begin
      if (loaded_q) begin
        row_q <= '0;
        col_q <= '0;
      end
      if (pos_inc >= total) begin
        loaded_q <= 1'b1;
        pos_q    <= '0;
      end else begin
        loaded_q <= 1'b0;
        pos_q    <= pos_inc[ADDR_W-1:0];
      end
    end else if (cmd_i.red_commit) begin
      row_q <= red_r;
      col_q <= red_c;
    end else if (cmd_i.src) begin
      if (col_inc >= w) begin
        col_q <= '0;
        row_q <= (row_inc >= h) ? '0 : row_inc[COORD_W-1:0];
      end else begin
        col_q <= col_inc[COORD_W-1:0];
      end
    end
  end

  // frame store
  logic [ADDR_W:0]    raddr_full;
  logic [PIXEL_W-1:0] rdata;

  assign raddr_full = (ADDR_W + 1)'(sr_q) * (ADDR_W + 1)'(w) + (ADDR_W + 1)'(sc_q);

  iws_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (pos_cur),
    .wdata_i (pixel_in_i),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr_full[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  // result register
  logic               out_valid_q;
  logic [PIXEL_W-1:0] pixel_q;
  logic               ready_res_q, last_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pixel_q     <= loaded_q ? rdata : '0;
      ready_res_q <= loaded_q;
      last_pix_q  <= loaded_q & last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = pixel_q;
  assign ready_res_o  = ready_res_q;
  assign last_pixel_o = last_pix_q;

  assign sts_o.loaded      = loaded_q;
  assign sts_o.need_reduce = (DIM_W'(row_q) >= h) || (DIM_W'(col_q) >= w);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

endmodule

FILE: rtl/image_wrap_shift_top.sv
// Top level of the image wrap-shift engine: controller plus datapath.
// Depends on iws_pkg, iws_if, iws_ctrl, iws_dp (and iws_ram below it).
//
//   port      dir  carries
//   item_i    in   command (load/fetch), pixel_in
//   result_o  out  pixel_out, ready_res, last_pixel (one per fetch)
//   cfg_i     in   index, data (width, height, x/y shift fractions)
//
// Load: transactions are taken back to back, one frame-store write port.
// Fetch: offset multiply, rounding, wrap, address multiply, RAM read; an 8-step
//   remainder comes first when the sizes were changed below the current output
//   position. A fetch before the frame is loaded goes straight to the result register.
// Reset is asynchronous; the frame store has no clearing pass.
// A stalled result does not hold off loads and lets one more fetch in; that fetch then
//   waits in its output state until the result register frees, holding off the input.
module image_wrap_shift_top
  import iws_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  iws_item_if.sink     item_i,
  iws_result_if.source result_o,
  iws_cfg_if.sink      cfg_i
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_i.ready = 1'b1;

  iws_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (item_i.valid),
    .in_command_i (item_i.command),
    .in_ready_o   (item_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  iws_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pixel_in_i   (item_i.pixel_in),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_valid_o  (result_o.valid),
    .out_ready_i  (result_o.ready),
    .pixel_out_o  (result_o.pixel_out),
    .ready_res_o  (result_o.ready_res),
    .last_pixel_o (result_o.last_pixel)
  );

endmodule

FILE: rtl/iws_checker.sv
// Port-level assertions for image_wrap_shift_top, attached by bind.
// Depends on iws_pkg for widths and command codes.
module iws_checker
  import iws_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_command_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [PIXEL_W-1:0] pixel_out_i,
  input logic               ready_res_i,
  input logic               last_pixel_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(pixel_out_i) && $stable(ready_res_i) && $stable(last_pixel_i))
    else $error("result payload changed while stalled");

  a_not_ready_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !ready_res_i |-> pixel_out_i == '0 && !last_pixel_i)
    else $error("fetch before frame loaded returned data");

  a_last_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_pixel_i |-> ready_res_i)
    else $error("last pixel flagged on unloaded frame");

  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_command_i == CMD_FETCH |=> !in_ready_i)
    else $error("fetch transaction did not occupy the engine");

endmodule

bind image_wrap_shift_top iws_checker u_iws_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .in_command_i (item_i.command),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .pixel_out_i  (result_o.pixel_out),
  .ready_res_i  (result_o.ready_res),
  .last_pixel_i (result_o.last_pixel)
);

FILE: test/tb_top.sv
// Testbench for image_wrap_shift_top: loads frames, fetches the rolled image and checks
// every result against an in-bench predictor of the wrap-around shift.
// Depends on iws_pkg, the iws_if interfaces and the RTL top level.
module tb_top;
  import iws_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam int ITEM_TARGET   = 1350;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               ready_res;
    logic               last;
  } rolled_px_t;

  logic clk_i;
  logic rst_ni;

  iws_item_if   item_if ();
  iws_result_if res_if ();
  iws_cfg_if    cfg_if ();

  image_wrap_shift_top u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  // predictor state
  rolled_px_t         rolled_q [$];
  logic [PIXEL_W-1:0] frame_copy [STORE_DEPTH];
  int unsigned        load_pos = 0;
  int unsigned        out_r = 0;
  int unsigned        out_c = 0;
  int unsigned        written_cnt = 0;
  bit                 frame_full = 1'b0;
  logic [DIM_W-1:0]   width_reg = 9'd256;
  logic [DIM_W-1:0]   height_reg = 9'd256;
  logic [FRAC_W-1:0]  xfrac_reg = '0;
  logic [FRAC_W-1:0]  yfrac_reg = '0;

  int err_cnt = 0;
  int items_sent = 0;
  int src_idle_pct = 13;
  int snk_idle_pct = 53;
  int hold_len = 0;

  function automatic int unsigned active_size(input logic [DIM_W-1:0] v,
                                              input int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // forward offset in [0,size): output index i reads source (i + size - off) mod size
  function automatic int unsigned roll_offset(input logic [FRAC_W-1:0] frac,
                                              input int unsigned size);
    logic [FRAC_W-1:0] mag;
    int unsigned       off;
    mag = frac[FRAC_W-1] ? -frac : frac;
    off = (size * mag[15:0] + 32768) >> 16;
    if (off >= size) off = 0;
    if (frac[FRAC_W-1] && off != 0) off = size - off;
    return off;
  endfunction

  function automatic bit roll_apply(input logic cmd, input logic [PIXEL_W-1:0] px,
                                    output rolled_px_t res);
    int unsigned w, h, r, c, sr, sc;
    w   = active_size(width_reg, MAX_WIDTH);
    h   = active_size(height_reg, MAX_HEIGHT);
    res = '0;
    if (cmd == CMD_LOAD) begin
      if (frame_full) begin
        frame_full = 1'b0;
        load_pos   = 0;
        out_r      = 0;
        out_c      = 0;
      end
      if (load_pos < STORE_DEPTH) frame_copy[load_pos] = px;
      load_pos++;
      if (load_pos > written_cnt) written_cnt = load_pos;
      if (load_pos >= w * h) begin
        frame_full = 1'b1;
        load_pos   = 0;
      end
      return 1'b0;
    end
    if (!frame_full) return 1'b1;
    r  = out_r % h;
    c  = out_c % w;
    sc = (c + w - roll_offset(xfrac_reg, w)) % w;
    sr = (r + h - roll_offset(yfrac_reg, h)) % h;
    res.pixel     = frame_copy[sr * w + sc];
    res.ready_res = 1'b1;
    res.last      = (r == h - 1) && (c == w - 1);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    out_r = r;
    out_c = c;
    return 1'b1;
  endfunction

  function automatic logic [FRAC_W-1:0] pick_shift();
    int s;
    case ($urandom_range(7))
      0: s = 0;
      1: s = 65536;
      2: s = -65536;
      3: s = 32768;
      4: s = -32768;
      default: s = int'($urandom_range(131072)) - 65536;
    endcase
    return FRAC_W'(s);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result checker and predictor, one transaction per accepted handshake
  always @(posedge clk_i) begin : scoreboard
    rolled_px_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (rolled_q.size() == 0) begin
          $error("unexpected result: pixel_out %h ready_res %b last_pixel %b",
                 res_if.pixel_out, res_if.ready_res, res_if.last_pixel);
          err_cnt++;
        end else begin
          want = rolled_q.pop_front();
          if (res_if.pixel_out !== want.pixel) begin
            $error("pixel_out: expected %h, got %h", want.pixel, res_if.pixel_out);
            err_cnt++;
          end
          if (res_if.ready_res !== want.ready_res) begin
            $error("ready_res: expected %b, got %b", want.ready_res, res_if.ready_res);
            err_cnt++;
          end
          if (res_if.last_pixel !== want.last) begin
            $error("last_pixel: expected %b, got %b", want.last, res_if.last_pixel);
            err_cnt++;
          end
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_WIDTH:  width_reg  = cfg_if.data[DIM_W-1:0];
          REG_HEIGHT: height_reg = cfg_if.data[DIM_W-1:0];
          REG_XSHIFT: xfrac_reg  = cfg_if.data[FRAC_W-1:0];
          REG_YSHIFT: yfrac_reg  = cfg_if.data[FRAC_W-1:0];
          default: ;
        endcase
      end
      if (item_if.valid && item_if.ready) begin
        if (roll_apply(item_if.command, item_if.pixel_in, want)) rolled_q.push_back(want);
      end
    end
  end

  initial begin : result_sink
    int stall;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        stall    = hold_len;
        hold_len = 0;
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [PIXEL_W-1:0] px);
    if (items_sent < ITEM_TARGET / 3) begin
      src_idle_pct = 13;
      snk_idle_pct = 53;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      src_idle_pct = 53;
      snk_idle_pct = 13;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
    if ($urandom_range(99) < src_idle_pct) begin
      item_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    item_if.valid   <= 1'b1;
    item_if.command <= cmd;
    item_if.pixel_in <= px;
    do @(posedge clk_i); while (!item_if.ready);
    items_sent++;
  endtask

  task automatic send_loads(input int n);
    for (int i = 0; i < n; i++) send_item(CMD_LOAD, $urandom);
  endtask

  task automatic send_fetches(input int n);
    for (int i = 0; i < n; i++) send_item(CMD_FETCH, $urandom);
  endtask

  // wait for every pending result, then let in-flight loads finish
  task automatic settle();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (rolled_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [FRAC_W-1:0] x, input logic [FRAC_W-1:0] y);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_WIDTH, REG_HEIGHT, REG_XSHIFT, REG_YSHIFT};
    val = '{CFG_DATA_W'(w), CFG_DATA_W'(h), CFG_DATA_W'(x), CFG_DATA_W'(y)};
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i];
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_fetch_before_load();
    send_fetches(2);
  endtask

  task automatic test_basic_roll();
    settle();
    write_config(9'd3, 9'd2, 18'h0_8000, 18'h3_8000);
    send_item(CMD_LOAD, 32'h0000_0000);
    send_item(CMD_LOAD, 32'hFFFF_FFFF);
    send_item(CMD_LOAD, 32'hAAAA_AAAA);
    send_item(CMD_FETCH, $urandom);
    send_item(CMD_LOAD, 32'h5555_5555);
    send_loads(2);
    send_fetches(7);
  endtask

  task automatic test_special_sizes();
    settle();
    write_config(9'd0, 9'd0, 18'h1_0000, 18'h3_0000);
    send_loads(1);
    send_fetches(2);
    settle();
    write_config(9'd4, 9'd4, pick_shift(), pick_shift());
    send_loads(5);
    // shrink mid-load: next load completes the frame
    settle();
    write_config(9'd2, 9'd2, pick_shift(), pick_shift());
    send_loads(1);
    send_fetches(3);
    // shrink after load: output position wraps to new sizes
    settle();
    write_config(9'd2, 9'd1, 18'h3_C000, 18'h0_4000);
    send_fetches(3);
  endtask

  task automatic test_backpressure();
    settle();
    write_config(9'd8, 9'd4, pick_shift(), pick_shift());
    send_loads(32);
    hold_len = HOLD_CYCLES;
    send_fetches(40);
    settle();
  endtask

  task automatic test_size_extremes();
    settle();
    write_config(9'd511, 9'd1, pick_shift(), pick_shift());
    send_loads(256);
    send_fetches(256);
    settle();
    write_config(9'd0, 9'd256, pick_shift(), pick_shift());
    send_fetches(40);
    settle();
    write_config(9'd256, 9'd0, 18'h1_0000, 18'h3_0000);
    send_fetches(20);
    settle();
    write_config(9'd1, 9'd300, pick_shift(), pick_shift());
    send_fetches(20);
  endtask

  task automatic test_random_frames();
    logic [DIM_W-1:0] w, h;
    int unsigned      w_eff, h_eff, total, nload;
    bit               broken;
    while (items_sent < ITEM_TARGET) begin
      settle();
      w     = DIM_W'($urandom_range(16));
      h     = DIM_W'($urandom_range(16));
      w_eff = active_size(w, MAX_WIDTH);
      h_eff = active_size(h, MAX_HEIGHT);
      total = w_eff * h_eff;
      write_config(w, h, pick_shift(), pick_shift());
      broken = (total > 1) && ($urandom_range(9) == 0);
      nload  = broken ? $urandom_range(1, total - 1) : total;
      for (int i = 0; i < nload; i++) begin
        send_item(CMD_LOAD, $urandom);
        if (i + 1 < nload && $urandom_range(15) == 0) send_item(CMD_FETCH, $urandom);
      end
      if (!broken) begin
        send_fetches($urandom_range(1, 2 * total + 2));
        if ($urandom_range(3) == 0) begin
          settle();
          write_config(DIM_W'($urandom_range(1, w_eff)), DIM_W'($urandom_range(1, h_eff)),
                       pick_shift(), pick_shift());
          send_fetches($urandom_range(1, total + 2));
        end
      end
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    item_if.valid    <= 1'b0;
    item_if.command  <= CMD_LOAD;
    item_if.pixel_in <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= REG_WIDTH;
    cfg_if.data      <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_fetch_before_load();
    test_basic_roll();
    test_special_sizes();
    test_backpressure();
    test_size_extremes();
    test_random_frames();
    settle();
    if (err_cnt == 0 && rolled_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/iws_pkg.sv
rtl/iws_if.sv
rtl/iws_ram.sv
rtl/iws_ctrl.sv
rtl/iws_dp.sv
rtl/image_wrap_shift_top.sv
rtl/iws_checker.sv
test/tb_top.sv
